// ===== hdl/nfpa_pkg.sv =====
package nfpa_pkg;

    // bitmap row geometry
    localparam int WORD_W = 64;
    localparam int BIT_W  = $clog2(WORD_W);

    // field widths
    localparam int PORT_W    = 16;
    localparam int CFG_IDX_W = 1;

    // default pool depth
    localparam int POOL_DEPTH_DEF = 4096;

    // register reset values
    localparam logic [PORT_W-1:0] FIRST_PORT_RST = 16'd1024;
    localparam logic [PORT_W-1:0] LAST_PORT_RST  = 16'd5119;

    // operation codes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PORT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_PORT  = 1'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RD0,
        ST_SCAN,
        ST_REL,
        ST_FIN
    } state_t;

    // bitmap write kinds
    typedef enum logic [1:0] {
        RAM_WR_NONE,
        RAM_WR_CLR_ROW,
        RAM_WR_SET_BIT,
        RAM_WR_CLR_BIT
    } ram_wr_op_t;

    // which bits of a fetched row may be granted
    typedef struct packed {
        logic             last_row;
        logic [BIT_W-1:0] last_bit;
        logic             first_visit;
        logic             final_visit;
        logic [BIT_W-1:0] start_bit;
    } scan_mask_t;

    // lowest free bit of a row
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bit_idx;
    } free_find_t;

    function automatic int calc_rows(input int depth);
        return (depth + WORD_W - 1) / WORD_W;
    endfunction

    function automatic int calc_row_w(input int depth);
        int rows;
        rows = calc_rows(depth);
        return (rows > 1) ? $clog2(rows) : 1;
    endfunction

endpackage

// ===== hdl/nfpa_bitmap_ram.sv =====
module nfpa_bitmap_ram #(
    parameter int POOL_DEPTH = nfpa_pkg::POOL_DEPTH_DEF,
    localparam int ROWS  = nfpa_pkg::calc_rows(POOL_DEPTH),
    localparam int ROW_W = nfpa_pkg::calc_row_w(POOL_DEPTH)
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [ROW_W-1:0]             rd_row,
    output logic [nfpa_pkg::WORD_W-1:0]  rd_data,
    input  nfpa_pkg::ram_wr_op_t         wr_op,
    input  logic [ROW_W-1:0]             wr_row,
    input  logic [nfpa_pkg::BIT_W-1:0]   wr_bit
);

    logic [nfpa_pkg::WORD_W-1:0] map_mem [ROWS];
    logic [nfpa_pkg::WORD_W-1:0] rd_data_reg;

    // write port: row clear or single bit update
    always_ff @(posedge clk)
    begin
        case (wr_op)
            nfpa_pkg::RAM_WR_CLR_ROW: map_mem[wr_row] <= '0;
            nfpa_pkg::RAM_WR_SET_BIT: map_mem[wr_row][wr_bit] <= 1'b1;
            nfpa_pkg::RAM_WR_CLR_BIT: map_mem[wr_row][wr_bit] <= 1'b0;
            default: ;
        endcase
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/nfpa_rem_unit.sv =====
module nfpa_rem_unit #(
    parameter int POOL_DEPTH = nfpa_pkg::POOL_DEPTH_DEF,
    localparam int POS_W  = nfpa_pkg::calc_row_w(POOL_DEPTH) + nfpa_pkg::BIT_W,
    localparam int SIZE_W = POS_W + 1,
    localparam int CNT_W  = $clog2(POS_W + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [POS_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [POS_W-1:0]  rem
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  dvd_reg, dvd_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [SIZE_W-1:0] trial;

    // restoring remainder, one dividend bit per cycle
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[POS_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(POS_W);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= divisor)
            begin
                rem_next = POS_W'(trial - divisor);
            end
            else
            begin
                rem_next = trial[POS_W-1:0];
            end
            dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    // remainder must land below the divisor
    ap_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, rem_reg} < divisor))
        else $error("remainder not below divisor");

endmodule

// ===== hdl/nfpa_first_free.sv =====
module nfpa_first_free (
    input  logic [nfpa_pkg::WORD_W-1:0] word,
    input  nfpa_pkg::scan_mask_t        mask,
    output nfpa_pkg::free_find_t        found
);

    logic [nfpa_pkg::WORD_W-1:0] cand;

    // free bits that are inside the pool and in the current scan window
    always_comb
    begin
        for (int i = 0; i < nfpa_pkg::WORD_W; i++)
        begin
            cand[i] = !word[i]
                && !(mask.last_row && (nfpa_pkg::BIT_W'(i) > mask.last_bit))
                && !(mask.first_visit && (nfpa_pkg::BIT_W'(i) < mask.start_bit))
                && !(mask.final_visit && (nfpa_pkg::BIT_W'(i) >= mask.start_bit));
        end
    end

    // lowest candidate wins
    always_comb
    begin
        found.hit     = 1'b0;
        found.bit_idx = '0;
        for (int i = nfpa_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found.hit     = 1'b1;
                found.bit_idx = nfpa_pkg::BIT_W'(i);
            end
        end
    end

endmodule

// ===== hdl/next_fit_port_allocator.sv =====
// Acquire: an optional bit-serial remainder step when the stored offset is at or past
//   the pool size, then 1 to rows + 1 bitmap rows read, one 64-bit row per cycle from
//   the single read port, until a free bit is found or the start row comes round again.
// Release: clears the port's bit when it lies inside the pool. One word in flight; the
//   next is taken only once the result is registered. Reset clears registers at once,
//   then a clearing pass of one row per cycle holds in_stall high.
module next_fit_port_allocator #(
    parameter int POOL_DEPTH = nfpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nfpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfpa_pkg::PORT_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [nfpa_pkg::PORT_W-1:0]     port_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            success,
    output logic [nfpa_pkg::PORT_W-1:0]     port_out
);

    localparam int ROWS   = nfpa_pkg::calc_rows(POOL_DEPTH);
    localparam int ROW_W  = nfpa_pkg::calc_row_w(POOL_DEPTH);
    localparam int BIT_W  = nfpa_pkg::BIT_W;
    localparam int POS_W  = ROW_W + BIT_W;
    localparam int SIZE_W = POS_W + 1;
    localparam int PORT_W = nfpa_pkg::PORT_W;
    localparam int WIDE_W = PORT_W + 1;

    nfpa_pkg::state_t state_reg, state_next;

    logic [PORT_W-1:0] first_port_reg, last_port_reg;
    logic [POS_W-1:0]  next_off_reg, next_off_next;
    logic [ROW_W-1:0]  clr_row_reg;
    logic              out_valid_reg;

    logic              op_reg;
    logic [PORT_W-1:0] port_in_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [POS_W-1:0]  start_reg;
    logic [ROW_W-1:0]  iss_row_reg, ev_row_reg;
    logic              iss_wrap_reg, ev_wrap_reg;
    logic              res_ok_reg;
    logic [PORT_W-1:0] res_port_reg;
    logic              success_reg;
    logic [PORT_W-1:0] port_out_reg;

    logic              in_accept;
    logic [WIDE_W-1:0] span;
    logic [SIZE_W-1:0] size_now;
    logic              off_stale;
    logic [POS_W-1:0]  last_pos;
    logic [ROW_W-1:0]  last_row;
    logic [ROW_W-1:0]  start_row;
    logic [ROW_W-1:0]  row_src, row_adv;
    logic              wrap_src;
    logic [POS_W-1:0]  hit_idx;
    logic [SIZE_W-1:0] hit_inc;
    logic [PORT_W-1:0] rel_diff;
    logic              rel_ok;
    logic              out_load;
    logic              rem_start, rem_done;
    logic [POS_W-1:0]  rem_val;

    logic                       ram_rd_en;
    logic [nfpa_pkg::WORD_W-1:0] ram_rd_data;
    nfpa_pkg::ram_wr_op_t        ram_wr_op;
    logic [ROW_W-1:0]           ram_wr_row;
    logic [BIT_W-1:0]           ram_wr_bit;

    nfpa_pkg::scan_mask_t smask;
    nfpa_pkg::free_find_t found;

    assign in_accept = in_valid && !in_stall;

    // pool size from the registers, capped at the bitmap depth, zero when last is below first
    always_comb
    begin
        span = {1'b0, last_port_reg} - {1'b0, first_port_reg} + 1'b1;
        if (last_port_reg < first_port_reg)
        begin
            size_now = '0;
        end
        else if (span > WIDE_W'(POOL_DEPTH))
        begin
            size_now = SIZE_W'(POOL_DEPTH);
        end
        else
        begin
            size_now = SIZE_W'(span);
        end
    end

    assign off_stale = ({1'b0, next_off_reg} >= size_now);

    // scan geometry
    assign last_pos  = POS_W'(size_reg - 1'b1);
    assign last_row  = last_pos[POS_W-1:BIT_W];
    assign start_row = start_reg[POS_W-1:BIT_W];
    assign row_src   = (state_reg == nfpa_pkg::ST_RD0) ? start_row : iss_row_reg;
    assign wrap_src  = (state_reg == nfpa_pkg::ST_RD0) ? 1'b0 : iss_wrap_reg;
    assign row_adv   = (row_src == last_row) ? '0 : row_src + 1'b1;

    // mask for the row now at the read port output
    always_comb
    begin
        smask.last_row    = (ev_row_reg == last_row);
        smask.last_bit    = last_pos[BIT_W-1:0];
        smask.first_visit = !ev_wrap_reg && (ev_row_reg == start_row);
        smask.final_visit = ev_wrap_reg && (ev_row_reg == start_row);
        smask.start_bit   = start_reg[BIT_W-1:0];
    end

    // grant position and the offset after it
    assign hit_idx       = {ev_row_reg, found.bit_idx};
    assign hit_inc       = {1'b0, hit_idx} + 1'b1;
    assign next_off_next = (hit_inc == size_reg) ? '0 : hit_inc[POS_W-1:0];

    // release range check
    assign rel_diff = port_in_reg - first_port_reg;
    assign rel_ok   = (port_in_reg >= first_port_reg) && (port_in_reg <= last_port_reg)
                   && ({1'b0, rel_diff} < WIDE_W'(size_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfpa_pkg::ST_CLEAR:
            begin
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = nfpa_pkg::ST_IDLE;
                end
            end
            nfpa_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == nfpa_pkg::OP_RELEASE)
                    begin
                        state_next = nfpa_pkg::ST_REL;
                    end
                    else if (size_now == '0)
                    begin
                        state_next = nfpa_pkg::ST_FIN;
                    end
                    else if (off_stale)
                    begin
                        state_next = nfpa_pkg::ST_MOD;
                    end
                    else
                    begin
                        state_next = nfpa_pkg::ST_RD0;
                    end
                end
            end
            nfpa_pkg::ST_MOD:
            begin
                if (rem_done)
                begin
                    state_next = nfpa_pkg::ST_RD0;
                end
            end
            nfpa_pkg::ST_RD0:
            begin
                state_next = nfpa_pkg::ST_SCAN;
            end
            nfpa_pkg::ST_SCAN:
            begin
                if (found.hit || smask.final_visit)
                begin
                    state_next = nfpa_pkg::ST_FIN;
                end
            end
            nfpa_pkg::ST_REL:
            begin
                state_next = nfpa_pkg::ST_FIN;
            end
            nfpa_pkg::ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = nfpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfpa_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall   = 1'b1;
        rem_start  = 1'b0;
        ram_rd_en  = 1'b0;
        ram_wr_op  = nfpa_pkg::RAM_WR_NONE;
        ram_wr_row = ev_row_reg;
        ram_wr_bit = found.bit_idx;
        out_load   = 1'b0;
        case (state_reg)
            nfpa_pkg::ST_CLEAR:
            begin
                ram_wr_op  = nfpa_pkg::RAM_WR_CLR_ROW;
                ram_wr_row = clr_row_reg;
            end
            nfpa_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                rem_start = in_valid && (operation == nfpa_pkg::OP_ACQUIRE)
                         && (size_now != '0) && off_stale;
            end
            nfpa_pkg::ST_RD0:
            begin
                ram_rd_en = 1'b1;
            end
            nfpa_pkg::ST_SCAN:
            begin
                ram_rd_en = 1'b1;
                if (found.hit)
                begin
                    ram_wr_op = nfpa_pkg::RAM_WR_SET_BIT;
                end
            end
            nfpa_pkg::ST_REL:
            begin
                ram_wr_row = rel_diff[POS_W-1:BIT_W];
                ram_wr_bit = rel_diff[BIT_W-1:0];
                if (rel_ok)
                begin
                    ram_wr_op = nfpa_pkg::RAM_WR_CLR_BIT;
                end
            end
            nfpa_pkg::ST_FIN:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nfpa_pkg::ST_CLEAR;
            first_port_reg <= nfpa_pkg::FIRST_PORT_RST;
            last_port_reg  <= nfpa_pkg::LAST_PORT_RST;
            next_off_reg   <= '0;
            clr_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    nfpa_pkg::CFG_FIRST_PORT: first_port_reg <= cfg_data;
                    nfpa_pkg::CFG_LAST_PORT:  last_port_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == nfpa_pkg::ST_CLEAR)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
            if ((state_reg == nfpa_pkg::ST_SCAN) && found.hit)
            begin
                next_off_reg <= next_off_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == nfpa_pkg::ST_IDLE) && in_accept)
        begin
            op_reg       <= operation;
            port_in_reg  <= port_in;
            size_reg     <= size_now;
            start_reg    <= next_off_reg;
            res_ok_reg   <= 1'b0;
            res_port_reg <= '0;
        end
        if ((state_reg == nfpa_pkg::ST_MOD) && rem_done)
        begin
            start_reg <= rem_val;
        end
        if ((state_reg == nfpa_pkg::ST_RD0) || (state_reg == nfpa_pkg::ST_SCAN))
        begin
            ev_row_reg   <= row_src;
            ev_wrap_reg  <= wrap_src;
            iss_row_reg  <= row_adv;
            iss_wrap_reg <= wrap_src || (row_src == last_row);
        end
        if ((state_reg == nfpa_pkg::ST_SCAN) && found.hit)
        begin
            res_ok_reg   <= 1'b1;
            res_port_reg <= first_port_reg + PORT_W'(hit_idx);
        end
        if (state_reg == nfpa_pkg::ST_REL)
        begin
            res_ok_reg <= rel_ok;
        end
        if (out_load)
        begin
            success_reg  <= res_ok_reg;
            port_out_reg <= res_port_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign success   = success_reg;
    assign port_out  = port_out_reg;

    nfpa_bitmap_ram #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_row  (row_src),
        .rd_data (ram_rd_data),
        .wr_op   (ram_wr_op),
        .wr_row  (ram_wr_row),
        .wr_bit  (ram_wr_bit)
    );

    nfpa_first_free u_find (
        .word  (ram_rd_data),
        .mask  (smask),
        .found (found)
    );

    nfpa_rem_unit #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (next_off_reg),
        .divisor  (size_reg),
        .done     (rem_done),
        .rem      (rem_val)
    );

    // a grant always lies inside the pool
    ap_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == nfpa_pkg::ST_SCAN) && found.hit) |-> ({1'b0, hit_idx} < size_reg))
        else $error("grant outside pool");

    // after a successful acquire the next-fit offset is inside the pool
    ap_offset_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == nfpa_pkg::ST_FIN) && res_ok_reg && (op_reg == nfpa_pkg::OP_ACQUIRE))
        |-> ({1'b0, next_off_reg} < size_reg))
        else $error("next-fit offset outside pool");

    // a failed word never carries a port number
    ap_fail_no_port: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (success_reg || (port_out_reg == '0)))
        else $error("port number on failed word");

    // one word at a time
    ap_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input taken while busy");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_DEPTH = nfpa_pkg::POOL_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 600000;
    // margin for the slowest acquire: a full wrapping scan plus the remainder step
    localparam int TAIL_CYCLES = 120;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_WORDS = 50;

    // one expected result word
    typedef struct packed {
        logic                        success;
        logic [nfpa_pkg::PORT_W-1:0] port;
    } grant_t;

    // Tracks the pool the same way the block does and checks its results
    class port_grant_tracker;
        logic [nfpa_pkg::PORT_W-1:0] first_port;
        logic [nfpa_pkg::PORT_W-1:0] last_port;
        bit                          used_map [POOL_DEPTH];
        int unsigned                 next_offset;
        grant_t                      pending_grants [$];
        int unsigned                 n_errors;
        int unsigned                 n_results;

        function new();
            first_port  = nfpa_pkg::FIRST_PORT_RST;
            last_port   = nfpa_pkg::LAST_PORT_RST;
            next_offset = 0;
            n_errors    = 0;
            n_results   = 0;
            foreach (used_map[i])
                used_map[i] = 1'b0;
        endfunction

        function void set_reg(logic [nfpa_pkg::CFG_IDX_W-1:0] idx,
                              logic [nfpa_pkg::PORT_W-1:0] val);
            if (idx == nfpa_pkg::CFG_FIRST_PORT)
                first_port = val;
            else
                last_port = val;
        endfunction

        // number of entries in the pool, capped at the bitmap depth
        function int unsigned pool_size();
            int unsigned n;
            if (last_port < first_port)
                return 0;
            n = int'(last_port) - int'(first_port) + 1;
            if (n > POOL_DEPTH)
                n = POOL_DEPTH;
            return n;
        endfunction

        function int unsigned pending();
            return pending_grants.size();
        endfunction

        // apply one accepted request and queue the result it should give
        function void note_request(logic op, logic [nfpa_pkg::PORT_W-1:0] port);
            int unsigned size;
            int unsigned start;
            int unsigned idx;
            int          sum;
            grant_t      g;
            size = pool_size();
            g = '0;
            if (op == nfpa_pkg::OP_ACQUIRE)
            begin
                if (size != 0)
                begin
                    start = next_offset % size;
                    // next-fit scan with wrap at the pool end
                    for (int unsigned i = 0; i < size && !g.success; i++)
                    begin
                        idx = start + i;
                        if (idx >= size)
                            idx -= size;
                        if (!used_map[idx])
                        begin
                            used_map[idx] = 1'b1;
                            sum = int'(first_port) + idx;
                            g.port = sum[nfpa_pkg::PORT_W-1:0];
                            next_offset = (idx + 1) % size;
                            g.success = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                if (port >= first_port && port <= last_port)
                begin
                    idx = port - first_port;
                    if (idx < size)
                    begin
                        used_map[idx] = 1'b0;
                        g.success = 1'b1;
                    end
                end
            end
            pending_grants.push_back(g);
        endfunction

        task report_mismatch(string msg);
            n_errors++;
            $display("[%0t] MISMATCH result %0d: %s", $realtime, n_results, msg);
        endtask

        task check_grant(logic s, logic [nfpa_pkg::PORT_W-1:0] p);
            grant_t g;
            if (pending_grants.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word success=%0b port=%0d", s, p));
                return;
            end
            g = pending_grants.pop_front();
            if (s !== g.success)
                report_mismatch($sformatf("success %0b, want %0b", s, g.success));
            if (p !== g.port)
                report_mismatch($sformatf("port_out %0d, want %0d", p, g.port));
            n_results++;
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [nfpa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [nfpa_pkg::PORT_W-1:0]    cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           operation;
    logic [nfpa_pkg::PORT_W-1:0]    port_in;
    logic                           out_valid;
    logic                           out_stall;
    logic                           success;
    logic [nfpa_pkg::PORT_W-1:0]    port_out;

    port_grant_tracker tracker = new();
    bit                quiet = 1'b0;
    int unsigned       cycle_count = 0;

    next_fit_port_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .port_in   (port_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .success   (success),
        .port_out  (port_out)
    );

    always #6 clk = ~clk;

    // hard stop on a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int idle_cycles();
        if (quiet)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // offer one request word and wait for it to be taken
    task automatic send_word(input logic op, input logic [nfpa_pkg::PORT_W-1:0] port);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        port_in   <= port;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_request(op, port);
    endtask

    // hold off until every queued result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    // reprogram the pool bounds while the block is idle
    task automatic set_pool(input logic [nfpa_pkg::PORT_W-1:0] lo,
                            input logic [nfpa_pkg::PORT_W-1:0] hi);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= nfpa_pkg::CFG_FIRST_PORT;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= nfpa_pkg::CFG_LAST_PORT;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_reg(nfpa_pkg::CFG_FIRST_PORT, lo);
        tracker.set_reg(nfpa_pkg::CFG_LAST_PORT, hi);
    endtask

    // random pool bounds: tiny, row-crossing, mid, full range, empty, near cap, top end
    task automatic pick_pool(output logic [nfpa_pkg::PORT_W-1:0] lo,
                             output logic [nfpa_pkg::PORT_W-1:0] hi);
        int kind;
        int size;
        int base;
        kind = $urandom_range(0, 6);
        case (kind)
            0: size = $urandom_range(1, 8);
            1: size = $urandom_range(9, 130);
            2: size = $urandom_range(131, 400);
            5: size = $urandom_range(4000, 4200);
            default: size = $urandom_range(1, 40);
        endcase
        base = (kind == 6) ? 65536 - size : $urandom_range(0, 65536 - size);
        lo = base[nfpa_pkg::PORT_W-1:0];
        hi = nfpa_pkg::PORT_W'(base + size - 1);
        if (kind == 3)
        begin
            lo = '0;
            hi = '1;
        end
        else if (kind == 4)
        begin
            base = $urandom_range(1, 65535);
            lo = base[nfpa_pkg::PORT_W-1:0];
            hi = nfpa_pkg::PORT_W'($urandom_range(0, base - 1));
        end
    endtask

    // mostly acquires and in-pool releases, some releases just outside, some noise
    task automatic run_random_phase(input int n_words);
        int unsigned                 roll;
        int                          pick;
        logic                        op;
        logic [nfpa_pkg::PORT_W-1:0] port;
        for (int k = 0; k < n_words; k++)
        begin
            roll = $urandom_range(0, 99);
            port = nfpa_pkg::PORT_W'($urandom_range(0, 65535));
            op = nfpa_pkg::OP_ACQUIRE;
            if (roll >= 58)
            begin
                op = nfpa_pkg::OP_RELEASE;
                if (roll < 90)
                    pick = int'(tracker.first_port) + $urandom_range(0, tracker.pool_size());
                else if (roll < 95)
                    pick = int'(tracker.first_port) - 1;
                else
                    pick = port;
                port = pick[nfpa_pkg::PORT_W-1:0];
            end
            send_word(op, port);
        end
    endtask

    // result side: random stall ahead of each word
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_cycles();
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            tracker.check_grant(success, port_out);
        end
    end

    // request side and run control
    initial
    begin
        logic [nfpa_pkg::PORT_W-1:0] lo;
        logic [nfpa_pkg::PORT_W-1:0] hi;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = nfpa_pkg::CFG_FIRST_PORT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = nfpa_pkg::OP_ACQUIRE;
        port_in   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset pool: first grants, double release, releases around the edges
        send_word(nfpa_pkg::OP_ACQUIRE, 16'h0000);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'hFFFF);
        send_word(nfpa_pkg::OP_RELEASE, 16'd1024);
        send_word(nfpa_pkg::OP_RELEASE, 16'd1024);
        send_word(nfpa_pkg::OP_RELEASE, 16'd1023);
        send_word(nfpa_pkg::OP_RELEASE, 16'd5120);
        send_word(nfpa_pkg::OP_RELEASE, 16'h0000);
        send_word(nfpa_pkg::OP_RELEASE, 16'hFFFF);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'h5A5A);
        send_word(nfpa_pkg::OP_RELEASE, 16'd5119);
        drain();

        // two-entry pool with the offset left past its end, then exhaustion
        set_pool(16'd200, 16'd201);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'hA5A5);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'h0000);
        send_word(nfpa_pkg::OP_RELEASE, 16'd201);

        // single entry at the top of the port space
        set_pool(16'hFFFF, 16'hFFFF);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'h0000);
        send_word(nfpa_pkg::OP_RELEASE, 16'hFFFF);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'hFFFF);

        // empty pool
        set_pool(16'd10, 16'd9);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'h0000);
        send_word(nfpa_pkg::OP_RELEASE, 16'd9);
        send_word(nfpa_pkg::OP_RELEASE, 16'd10);

        // full port range, capped at the bitmap depth
        set_pool(16'h0000, 16'hFFFF);
        send_word(nfpa_pkg::OP_RELEASE, 16'd4095);
        send_word(nfpa_pkg::OP_RELEASE, 16'd4096);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'h1234);
        send_word(nfpa_pkg::OP_RELEASE, 16'hFFFF);
        send_word(nfpa_pkg::OP_ACQUIRE, 16'h0000);

        // random pools, every third one without idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            pick_pool(lo, hi);
            set_pool(lo, hi);
            quiet = (ph % 3 == 2);
            run_random_phase(PHASE_WORDS);
        end
        quiet = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        while (tracker.pending() != 0)
        begin
            tracker.report_mismatch("expected word never arrived");
            void'(tracker.pending_grants.pop_front());
        end

        if (tracker.n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
